// ===== rtl/core/greedy_coin_change_selector_core_macros.svh =====
// ------------------------------------------------------------------------
// greedy coin change selector assertion macros
// clocked concurrent checks on clk, disabled while rst_n is low
// ------------------------------------------------------------------------
`ifndef GREEDY_COIN_CHANGE_SELECTOR_CORE_MACROS_SVH
`define GREEDY_COIN_CHANGE_SELECTOR_CORE_MACROS_SVH

// check holds in the same cycle as the trigger
`define GCCS_ASSERT_NOW(label, trig, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (check)) \
        else $error(msg);

// check holds in the cycle after the trigger
`define GCCS_ASSERT_NEXT(label, trig, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (check)) \
        else $error(msg);

`endif

// ===== rtl/core/gccs_pkg.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// gccs_pkg
// shared widths, denomination tables and types of the coin change selector
// ------------------------------------------------------------------------
package gccs_pkg;

    localparam int COUNT_BITS  = 8;
    localparam int SUM_BITS    = 16;
    localparam int NUM_DENOMS  = 8;
    localparam int IDX_W       = 3;
    localparam int DVAL_W      = 8;

    // exact division by a denomination: q = (n * ceil(2^K / d)) >> K
    localparam int RECIP_SHIFT = SUM_BITS + DVAL_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_BITS + RECIP_W;
    localparam int SUB_W       = SUM_BITS + COUNT_BITS + DVAL_W;

    localparam logic [63:0] RECIP_BASE = 64'd1 << RECIP_SHIFT;

    // face values, smallest first
    localparam logic [DVAL_W-1:0] DENOM_VALUE [NUM_DENOMS] = '{
        8'd1, 8'd2, 8'd5, 8'd10, 8'd20, 8'd50, 8'd100, 8'd200
    };

    localparam logic [RECIP_W-1:0] DENOM_RECIP [NUM_DENOMS] = '{
        RECIP_W'((RECIP_BASE + 64'd0)   / 64'd1),
        RECIP_W'((RECIP_BASE + 64'd1)   / 64'd2),
        RECIP_W'((RECIP_BASE + 64'd4)   / 64'd5),
        RECIP_W'((RECIP_BASE + 64'd9)   / 64'd10),
        RECIP_W'((RECIP_BASE + 64'd19)  / 64'd20),
        RECIP_W'((RECIP_BASE + 64'd49)  / 64'd50),
        RECIP_W'((RECIP_BASE + 64'd99)  / 64'd100),
        RECIP_W'((RECIP_BASE + 64'd199) / 64'd200)
    };

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_ADD     = 2'd1,
        ACT_REQUEST = 2'd2
    } action_t;

    // broadcast count update to every cell
    typedef struct packed {
        logic             clear;
        logic             add;
        logic [IDX_W-1:0] add_idx;
    } cell_ctl_t;

    // request travelling down the row
    typedef struct packed {
        logic                valid;
        logic [SUM_BITS-1:0] rest;
    } token_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } denom_hit_t;

    // map a face value to its slot
    function automatic denom_hit_t find_denom(logic [DVAL_W-1:0] value);
        denom_hit_t res;
        res = '0;
        for (int k = 0; k < NUM_DENOMS; k++)
        begin
            if (value == DENOM_VALUE[k])
            begin
                res.hit = 1'b1;
                res.idx = IDX_W'(k);
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/gccs_cell.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// gccs_cell
// one denomination: holds its coin count and takes its share of a request
// ------------------------------------------------------------------------
module gccs_cell import gccs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_W-1:0]      idx,
    input  cell_ctl_t             ctl,
    input  token_t                up,
    output token_t                down,
    output logic [COUNT_BITS-1:0] taken
);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  a_valid_reg;
    logic [SUM_BITS-1:0]   a_rest_reg;
    logic [SUM_BITS-1:0]   a_fit_reg;
    logic [SUM_BITS-1:0]   a_fit_next;
    logic                  down_valid_reg;
    logic [SUM_BITS-1:0]   down_rest_reg;
    logic [SUM_BITS-1:0]   down_rest_next;
    logic [COUNT_BITS-1:0] taken_reg;
    logic [COUNT_BITS-1:0] taken_next;
    logic [PROD_W-1:0]     prod;
    logic [SUB_W-1:0]      used;

    // count update, saturating at full scale
    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.add && (ctl.add_idx == idx) && (count_reg != '1))
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
    end

    // first step: how many coins the incoming sum covers
    always_comb
    begin
        prod       = PROD_W'(up.rest) * PROD_W'(DENOM_RECIP[idx]);
        a_fit_next = prod[RECIP_SHIFT +: SUM_BITS];
    end

    // second step: limit by stock and pass on what is left
    always_comb
    begin
        if (SUB_W'(a_fit_reg) < SUB_W'(count_reg))
        begin
            taken_next = COUNT_BITS'(a_fit_reg);
        end
        else
        begin
            taken_next = count_reg;
        end
        used           = SUB_W'(taken_next) * SUB_W'(DENOM_VALUE[idx]);
        down_rest_next = SUM_BITS'(SUB_W'(a_rest_reg) - used);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            a_valid_reg    <= 1'b0;
            down_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            a_valid_reg    <= up.valid;
            down_valid_reg <= a_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (up.valid)
        begin
            a_rest_reg <= up.rest;
            a_fit_reg  <= a_fit_next;
        end
        if (a_valid_reg)
        begin
            down_rest_reg <= down_rest_next;
            taken_reg     <= taken_next;
        end
    end

    assign down  = '{valid: down_valid_reg, rest: down_rest_reg};
    assign taken = taken_reg;

endmodule

// ===== rtl/core/greedy_coin_change_selector_core.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// greedy_coin_change_selector_core
// coin stock per denomination with greedy change selection
// ------------------------------------------------------------------------
// usage:
//   a beat is taken at a rising edge where start is high and busy is low.
//   clear and add beats update the coin counts in that edge and leave busy
//   low, so they can follow each other every cycle while no request is busy.
//   a request beat raises busy and walks a row of eight cells, largest
//   denomination first; each cell divides, then limits and subtracts, with
//   a register after each step. done is high for one cycle once the request
//   leaves the last cell, with the taken_* counts and remainder valid then.
//   busy drops the cycle after done, so a new request is not taken until
//   the last one is through the row.
//   the result cannot be stalled: the receiver must take it in that cycle.
//   reset clears all counts and any request in flight.
//   requests never change the stored counts.
// ------------------------------------------------------------------------
`include "greedy_coin_change_selector_core_macros.svh"

module greedy_coin_change_selector_core import gccs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [7:0]  coin_value,
    input  logic [15:0] target_sum,
    output logic        done,
    output logic [7:0]  taken_one,
    output logic [7:0]  taken_two,
    output logic [7:0]  taken_five,
    output logic [7:0]  taken_ten,
    output logic [7:0]  taken_twenty,
    output logic [7:0]  taken_fifty,
    output logic [7:0]  taken_hundred,
    output logic [7:0]  taken_two_hundred,
    output logic [15:0] remainder
);

    logic                  busy_reg;
    logic                  accept;
    logic                  req_go;
    cell_ctl_t             ctl;
    denom_hit_t            hit;
    token_t                tok_w [NUM_DENOMS+1];
    logic [NUM_DENOMS-1:0] tok_valid;
    logic [COUNT_BITS-1:0] taken_w [NUM_DENOMS];

    assign accept = start && !busy_reg;
    assign hit    = find_denom(coin_value);

    // decode the incoming beat
    always_comb
    begin
        ctl    = '0;
        req_go = 1'b0;
        if (accept)
        begin
            case (action_t'(action))
                ACT_CLEAR:
                begin
                    ctl.clear = 1'b1;
                end
                ACT_ADD:
                begin
                    ctl.add     = hit.hit;
                    ctl.add_idx = hit.idx;
                end
                ACT_REQUEST:
                begin
                    req_go = 1'b1;
                end
                default:
                begin
                    req_go = 1'b0;
                end
            endcase
        end
    end

    assign tok_w[NUM_DENOMS] = '{valid: req_go, rest: SUM_BITS'(target_sum)};

    // row of cells, largest denomination at the head
    for (genvar g = 0; g < NUM_DENOMS; g++)
    begin : g_cell
        gccs_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .idx   (IDX_W'(g)),
            .ctl   (ctl),
            .up    (tok_w[g+1]),
            .down  (tok_w[g]),
            .taken (taken_w[g])
        );
        assign tok_valid[g] = tok_w[g].valid;
    end

    // request in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (req_go)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy              = busy_reg;
    assign done              = tok_w[0].valid;
    assign taken_one         = 8'(taken_w[0]);
    assign taken_two         = 8'(taken_w[1]);
    assign taken_five        = 8'(taken_w[2]);
    assign taken_ten         = 8'(taken_w[3]);
    assign taken_twenty      = 8'(taken_w[4]);
    assign taken_fifty       = 8'(taken_w[5]);
    assign taken_hundred     = 8'(taken_w[6]);
    assign taken_two_hundred = 8'(taken_w[7]);
    assign remainder         = 16'(tok_w[0].rest);

    // checks
    `GCCS_ASSERT_NOW(a_done_in_flight, done, busy_reg, "result beat without a request")
    `GCCS_ASSERT_NEXT(a_done_frees, done, !busy_reg, "busy held after result beat")
    `GCCS_ASSERT_NEXT(a_req_busy, req_go, busy_reg && !done, "request did not raise busy")
    `GCCS_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_valid), "more than one request in row")

endmodule
